FILE: rtl/core/point_line_distance_weight_top_macros.svh
// Assertion macros used by the checker file.
`ifndef POINT_LINE_DISTANCE_WEIGHT_TOP_MACROS_SVH
`define POINT_LINE_DISTANCE_WEIGHT_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pldw_pkg.sv
package pldw_pkg;

  // Default number of fraction bits of coordinates, distance and weight
  localparam int FRAC_BITS_DEF = 16;
  // Fraction bits of sine and cosine
  localparam int TRIG_BITS = 14;

  // Configuration address width and register indexes
  localparam int CFG_AW = 3;
  localparam logic [0:0] REG_BIN_SIZE = 1'b0;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] lor_offset;
    logic signed [15:0] lor_sine;
    logic signed [15:0] lor_cosine;
    logic signed [23:0] lor_slope;
    logic signed [31:0] lor_mid_z;
    logic [23:0]        dir_length;
    logic [19:0]        weight_factor;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        distance;
    logic signed [31:0] weight;
  } out_item_t;

endpackage

FILE: rtl/core/pldw_chan_if.sv
interface pldw_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/point_line_distance_weight_top.sv
// Point to line distance and voxel weight. One item per cycle enters a
// fully pipelined datapath, unless the pipeline stalls: line point and
// offsets, cross product, sum of squares, a one-bit-per-stage square root,
// a one-bit-per-stage divide by the direction length, a one-bit-per-stage
// divide by twice the bin size, and the weight scaling. The pipeline stalls
// as a whole only when its last stage and the output register both hold an
// item that the sink does not take. The user must write bin_size through
// the APB port only while no item is in flight; the block does not enforce it.
module point_line_distance_weight_top
  import pldw_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pldw_chan_if.sink         in_ch,
  pldw_chan_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int F    = FRAC_BITS;
  localparam int TB   = TRIG_BITS;
  localparam int W_PR = 48;
  localparam int W_D  = 36;
  localparam int W_PT = W_D + 24;
  localparam int W_PS = W_D + 16;
  localparam int W_RT = W_PT + 1 - F;
  localparam int W_RS = W_PS + 1 - TB;
  localparam int W_C  = ((W_RT > W_RS) ? W_RT : W_RS) + 1;
  localparam int H    = (W_C + 1) / 2;
  localparam int W_S  = 2 * W_C + 2;
  localparam int W_R  = W_C + 1;
  localparam int W_L  = 24;
  localparam int W_N2 = 32 + F;
  localparam int HN   = W_N2 / 2;
  localparam int W_NP = W_N2 + 20;

  localparam logic signed [W_PR:0] HALF_R = (W_PR + 1)'(1) << (TB - 1);
  localparam logic signed [W_PT:0] HALF_T = (W_PT + 1)'(1) << (F - 1);
  localparam logic signed [W_PS:0] HALF_S = (W_PS + 1)'(1) << (TB - 1);
  localparam logic [31:0]          BIN_RESET = 32'(1) << F;
  localparam logic [W_N2-1:0]      ONE = W_N2'(1) << F;
  localparam logic [W_NP-1:0]      RND_UP = (W_NP'(1) << F) - W_NP'(1);
  localparam logic [W_NP-1:0]      LIMIT = W_NP'(1) << (31 + F);
  localparam logic [31:0]          W_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [W_L-1:0] len;
    logic [19:0]    fac;
  } side_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [19:0] fac;
  } side2_t;

  function automatic logic signed [W_D-1:0] rnd_r(input logic signed [W_PR-1:0] v);
    logic signed [W_PR:0] t;
    t = (W_PR + 1)'(v) + HALF_R;
    return W_D'(t >>> TB);
  endfunction

  function automatic logic signed [W_C-1:0] rnd_t(input logic signed [W_PT-1:0] v);
    logic signed [W_PT:0] t;
    t = (W_PT + 1)'(v) + HALF_T;
    return W_C'(t >>> F);
  endfunction

  function automatic logic signed [W_C-1:0] rnd_s(input logic signed [W_PS-1:0] v);
    logic signed [W_PS:0] t;
    t = (W_PS + 1)'(v) + HALF_S;
    return W_C'(t >>> TB);
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [31:0] bin_r;
  logic [32:0] den;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= BIN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[2])
        REG_BIN_SIZE: bin_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BIN_SIZE: cfg_prdata = bin_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Doubled bin size, zero taken as one raw unit
  assign den = {(bin_r == '0) ? 32'd1 : bin_r, 1'b0};

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  logic      adv;
  logic      out_free;
  logic      out_v_r;
  out_item_t out_data_r;
  logic      w4_v_r;

  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = out_free || !w4_v_r;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  // ---------------------------------------------------------------------
  // Stage 1: line point products, z difference
  // ---------------------------------------------------------------------
  logic                   s1_v_r;
  logic signed [W_PR-1:0] s1_ps_r, s1_pc_r;
  logic signed [31:0]     s1_px_r, s1_py_r;
  logic signed [W_D-1:0]  s1_dz_r;
  logic signed [23:0]     s1_tn_r;
  logic signed [15:0]     s1_sn_r, s1_cs_r;
  side_t                  s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_ch.valid;
    if (adv) begin
      s1_ps_r <= in_ch.data.lor_offset * in_ch.data.lor_sine;
      s1_pc_r <= in_ch.data.lor_offset * in_ch.data.lor_cosine;
      s1_px_r <= in_ch.data.point_x;
      s1_py_r <= in_ch.data.point_y;
      s1_dz_r <= W_D'(in_ch.data.point_z) - W_D'(in_ch.data.lor_mid_z);
      s1_tn_r <= in_ch.data.lor_slope;
      s1_sn_r <= in_ch.data.lor_sine;
      s1_cs_r <= in_ch.data.lor_cosine;
      s1_side_r.len <= (in_ch.data.dir_length == '0) ? W_L'(1) : in_ch.data.dir_length;
      s1_side_r.fac <= in_ch.data.weight_factor;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: vector from line point to voxel
  // ---------------------------------------------------------------------
  logic                  s2_v_r;
  logic signed [W_D-1:0] s2_dx_r, s2_dy_r, s2_dz_r;
  logic signed [23:0]    s2_tn_r;
  logic signed [15:0]    s2_sn_r, s2_cs_r;
  side_t                 s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_dx_r   <= W_D'(s1_px_r) + rnd_r(s1_ps_r);
      s2_dy_r   <= W_D'(s1_py_r) - rnd_r(s1_pc_r);
      s2_dz_r   <= s1_dz_r;
      s2_tn_r   <= s1_tn_r;
      s2_sn_r   <= s1_sn_r;
      s2_cs_r   <= s1_cs_r;
      s2_side_r <= s1_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: cross product terms
  // ---------------------------------------------------------------------
  logic                   s3_v_r;
  logic signed [W_PT-1:0] s3_dytn_r, s3_dxtn_r;
  logic signed [W_PS-1:0] s3_dzsn_r, s3_dzcs_r, s3_dxsn_r, s3_dycs_r;
  side_t                  s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv) begin
      s3_dytn_r <= s2_dy_r * s2_tn_r;
      s3_dxtn_r <= s2_dx_r * s2_tn_r;
      s3_dzsn_r <= s2_dz_r * s2_sn_r;
      s3_dzcs_r <= s2_dz_r * s2_cs_r;
      s3_dxsn_r <= s2_dx_r * s2_sn_r;
      s3_dycs_r <= s2_dy_r * s2_cs_r;
      s3_side_r <= s2_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: round terms and form the components
  // ---------------------------------------------------------------------
  logic                  s4_v_r;
  logic signed [W_C-1:0] s4_c_r [3];
  side_t                 s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      s4_c_r[0] <= rnd_t(s3_dytn_r) - rnd_s(s3_dzsn_r);
      s4_c_r[1] <= rnd_s(s3_dzcs_r) - rnd_t(s3_dxtn_r);
      s4_c_r[2] <= rnd_s(s3_dxsn_r) - rnd_s(s3_dycs_r);
      s4_side_r <= s3_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: magnitudes
  // ---------------------------------------------------------------------
  logic           s5_v_r;
  logic [W_C-1:0] s5_m_r [3];
  side_t          s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_m_r[k] <= s4_c_r[k][W_C-1] ? W_C'(-s4_c_r[k]) : W_C'(s4_c_r[k]);
      end
      s5_side_r <= s4_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: partial products of the squares
  // ---------------------------------------------------------------------
  logic                     s6_v_r;
  logic [2*(W_C-H)-1:0]     s6_hh_r [3];
  logic [W_C-1:0]           s6_hl_r [3];
  logic [2*H-1:0]           s6_ll_r [3];
  side_t                    s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s6_hh_r[k] <= s5_m_r[k][W_C-1:H] * s5_m_r[k][W_C-1:H];
        s6_hl_r[k] <= s5_m_r[k][W_C-1:H] * s5_m_r[k][H-1:0];
        s6_ll_r[k] <= s5_m_r[k][H-1:0] * s5_m_r[k][H-1:0];
      end
      s6_side_r <= s5_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: assemble the squares
  // ---------------------------------------------------------------------
  logic             s7_v_r;
  logic [2*W_C-1:0] s7_sq_r [3];
  side_t            s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s7_sq_r[k] <= ((2 * W_C)'(s6_hh_r[k]) << (2 * H))
                    + ((2 * W_C)'(s6_hl_r[k]) << (H + 1))
                    + (2 * W_C)'(s6_ll_r[k]);
      end
      s7_side_r <= s6_side_r;
    end
  end

  // ---------------------------------------------------------------------
  // Square root, one result bit per stage; entry 0 holds the sum
  // ---------------------------------------------------------------------
  logic           sq_v_r    [W_R+1];
  logic [W_S-1:0] sq_rem_r  [W_R+1];
  logic [W_R-1:0] sq_root_r [W_R+1];
  side_t          sq_side_r [W_R+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= s7_v_r;
    if (adv) begin
      sq_rem_r[0]  <= W_S'(s7_sq_r[0]) + W_S'(s7_sq_r[1]) + W_S'(s7_sq_r[2]);
      sq_root_r[0] <= '0;
      sq_side_r[0] <= s7_side_r;
    end
  end

  for (genvar k = 1; k <= W_R; k++) begin : g_sqrt
    localparam int B = W_R - k;
    logic [W_S:0] cand;
    logic         fit;

    // Trial bit B: (r + 2^B)^2 - r^2 against what is left of the sum
    always_comb begin
      cand = ((W_S + 1)'(sq_root_r[k-1]) << (B + 1)) + ((W_S + 1)'(1) << (2 * B));
      fit  = cand <= (W_S + 1)'(sq_rem_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k] <= 1'b0;
      else if (adv) sq_v_r[k] <= sq_v_r[k-1];
      if (adv) begin
        sq_rem_r[k]  <= fit ? W_S'((W_S + 1)'(sq_rem_r[k-1]) - cand) : sq_rem_r[k-1];
        sq_root_r[k] <= fit ? (sq_root_r[k-1] | (W_R'(1) << B)) : sq_root_r[k-1];
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide root by length; entry 0 holds the start remainder and the
  // saturation flag
  // ---------------------------------------------------------------------
  logic           d1_v_r   [33];
  logic [W_L-1:0] d1_rem_r [33];
  logic [31:0]    d1_num_r [33];
  logic [31:0]    d1_q_r   [33];
  logic           d1_sat_r [33];
  side_t          d1_side_r[33];
  logic [W_R+F-1:0] d1_n;

  assign d1_n = (W_R + F)'(sq_root_r[W_R]) << F;

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[0] <= 1'b0;
    else if (adv) d1_v_r[0] <= sq_v_r[W_R];
    if (adv) begin
      d1_rem_r[0]  <= W_L'(d1_n >> 32);
      d1_num_r[0]  <= d1_n[31:0];
      d1_q_r[0]    <= '0;
      d1_sat_r[0]  <= (W_R + 32)'(sq_root_r[W_R])
                      >= ((W_R + 32)'(sq_side_r[W_R].len) << (32 - F));
      d1_side_r[0] <= sq_side_r[W_R];
    end
  end

  for (genvar k = 1; k <= 32; k++) begin : g_div1
    logic [W_L:0] r2;
    logic         ge;

    always_comb begin
      r2 = {d1_rem_r[k-1], d1_num_r[k-1][31]};
      ge = r2 >= {1'b0, d1_side_r[k-1].len};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) d1_v_r[k] <= 1'b0;
      else if (adv) d1_v_r[k] <= d1_v_r[k-1];
      if (adv) begin
        d1_rem_r[k]  <= ge ? W_L'(r2 - {1'b0, d1_side_r[k-1].len}) : W_L'(r2);
        d1_num_r[k]  <= d1_num_r[k-1] << 1;
        d1_q_r[k]    <= {d1_q_r[k-1][30:0], ge};
        d1_sat_r[k]  <= d1_sat_r[k-1];
        d1_side_r[k] <= d1_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide distance by twice the bin size; entry 0 holds the distance
  // ---------------------------------------------------------------------
  logic            d2_v_r   [W_N2+1];
  logic [32:0]     d2_rem_r [W_N2+1];
  logic [W_N2-1:0] d2_num_r [W_N2+1];
  logic [W_N2-1:0] d2_q_r   [W_N2+1];
  side2_t          d2_side_r[W_N2+1];
  logic [31:0]     dist_sat;

  assign dist_sat = d1_sat_r[32] ? '1 : d1_q_r[32];

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r[0] <= 1'b0;
    else if (adv) d2_v_r[0] <= d1_v_r[32];
    if (adv) begin
      d2_rem_r[0]      <= '0;
      d2_num_r[0]      <= W_N2'(dist_sat) << F;
      d2_q_r[0]        <= '0;
      d2_side_r[0].dst <= dist_sat;
      d2_side_r[0].fac <= d1_side_r[32].fac;
    end
  end

  for (genvar k = 1; k <= W_N2; k++) begin : g_div2
    logic [33:0] r2;
    logic        ge;

    always_comb begin
      r2 = {d2_rem_r[k-1], d2_num_r[k-1][W_N2-1]};
      ge = r2 >= {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) d2_v_r[k] <= 1'b0;
      else if (adv) d2_v_r[k] <= d2_v_r[k-1];
      if (adv) begin
        d2_rem_r[k]  <= ge ? 33'(r2 - {1'b0, den}) : 33'(r2);
        d2_num_r[k]  <= d2_num_r[k-1] << 1;
        d2_q_r[k]    <= {d2_q_r[k-1][W_N2-2:0], ge};
        d2_side_r[k] <= d2_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Weight stage 1: split on ratio against one
  // ---------------------------------------------------------------------
  logic            w1_v_r, w1_le_r;
  logic [F:0]      w1_pos_r;
  logic [W_N2-1:0] w1_neg_r;
  side2_t          w1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) w1_v_r <= 1'b0;
    else if (adv) w1_v_r <= d2_v_r[W_N2];
    if (adv) begin
      w1_le_r   <= d2_q_r[W_N2] <= ONE;
      w1_pos_r  <= (F + 1)'(ONE - d2_q_r[W_N2]);
      w1_neg_r  <= d2_q_r[W_N2] - ONE;
      w1_side_r <= d2_side_r[W_N2];
    end
  end

  // ---------------------------------------------------------------------
  // Weight stage 2: scale by the factor, wide term in two halves
  // ---------------------------------------------------------------------
  logic                 w2_v_r, w2_le_r;
  logic [F+20:0]        w2_pp_r;
  logic [HN+19:0]       w2_nl_r;
  logic [W_N2-HN+19:0]  w2_nh_r;
  logic [31:0]          w2_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) w2_v_r <= 1'b0;
    else if (adv) w2_v_r <= w1_v_r;
    if (adv) begin
      w2_le_r   <= w1_le_r;
      w2_pp_r   <= w1_pos_r * w1_side_r.fac;
      w2_nl_r   <= w1_neg_r[HN-1:0] * w1_side_r.fac;
      w2_nh_r   <= w1_neg_r[W_N2-1:HN] * w1_side_r.fac;
      w2_dist_r <= w1_side_r.dst;
    end
  end

  // ---------------------------------------------------------------------
  // Weight stage 3: drop fraction, join halves
  // ---------------------------------------------------------------------
  logic            w3_v_r, w3_le_r;
  logic [20:0]     w3_pw_r;
  logic [W_NP-1:0] w3_np_r;
  logic [31:0]     w3_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) w3_v_r <= 1'b0;
    else if (adv) w3_v_r <= w2_v_r;
    if (adv) begin
      w3_le_r   <= w2_le_r;
      w3_pw_r   <= 21'(w2_pp_r >> F);
      w3_np_r   <= (W_NP'(w2_nh_r) << HN) + W_NP'(w2_nl_r);
      w3_dist_r <= w2_dist_r;
    end
  end

  // ---------------------------------------------------------------------
  // Weight stage 4: saturate and pick the weight
  // ---------------------------------------------------------------------
  logic            w4_sat;
  logic [W_NP-1:0] w4_nw;
  logic [31:0]     w4_wt;
  logic [31:0]     w4_dist_r, w4_wt_r;

  always_comb begin
    w4_sat = w3_np_r > LIMIT;
    w4_nw  = (w3_np_r + RND_UP) >> F;
    if (w3_le_r) w4_wt = 32'(w3_pw_r);
    else if (w4_sat) w4_wt = W_MIN;
    else w4_wt = 32'(W_NP'(0) - w4_nw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) w4_v_r <= 1'b0;
    else if (adv) w4_v_r <= w3_v_r;
    if (adv) begin
      w4_dist_r <= w3_dist_r;
      w4_wt_r   <= w4_wt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: hold the item until the sink takes it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_free) out_v_r <= w4_v_r;
    if (out_free) begin
      out_data_r.distance <= w4_dist_r;
      out_data_r.weight   <= w4_wt_r;
    end
  end

endmodule

FILE: rtl/core/pldw_checker.sv
module pldw_checker
  import pldw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [31:0]       cfg_pwdata,
  input logic [31:0]       cfg_prdata,
  input logic              cfg_pready
);

`include "point_line_distance_weight_top_macros.svh"

  // The port never inserts wait states
  `PLDW_ASSERT_ALWAYS(a_pready_high, cfg_pready, "cfg_pready dropped")

  // Read back the bin size written in the previous cycle
  `PLDW_ASSERT(a_bin_readback, $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_BIN_SIZE) && cfg_paddr[2] == REG_BIN_SIZE |-> cfg_prdata == $past(cfg_pwdata), "bin size readback mismatch")

  // A positive weight never exceeds the 20-bit factor
  `PLDW_ASSERT(a_weight_bound, out_valid |-> (out_data.weight[31] || out_data.weight[30:20] == '0), "positive weight out of range")

  // Hold a stalled item
  `PLDW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")

endmodule

bind point_line_distance_weight_top pldw_checker u_pldw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data),
  .cfg_psel   (cfg_psel),
  .cfg_penable(cfg_penable),
  .cfg_pwrite (cfg_pwrite),
  .cfg_paddr  (cfg_paddr),
  .cfg_pwdata (cfg_pwdata),
  .cfg_prdata (cfg_prdata),
  .cfg_pready (cfg_pready)
);

FILE: dv/tb_point_line_distance_weight_top.sv
`timescale 1ns / 100ps

module tb_point_line_distance_weight_top;
  import pldw_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int PIPE_DEPTH = 142;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1500;

  // Hold the predicted distance and weight of every item in flight
  class dist_weight_scoreboard;
    out_item_t   pending_q[$];
    int unsigned bin_size;
    int          errors;

    function new();
      bin_size = 32'd1 << FRAC;
      errors = 0;
    endfunction

    // Predict distance and weight of one voxel/line pair
    function out_item_t predict(in_item_t it);
      longint      px, py, pz, off, sn, cs, tn, zm;
      longint      dx, dy, dz, cx, cy, cz;
      logic [63:0] mx, my, mz, root, t, len, fac, dst, den, ratio, one, neg;
      logic [127:0] sum;
      longint      w;
      out_item_t   res;
      px = it.point_x; py = it.point_y; pz = it.point_z;
      off = it.lor_offset; sn = it.lor_sine; cs = it.lor_cosine;
      tn = it.lor_slope; zm = it.lor_mid_z;
      len = it.dir_length; fac = it.weight_factor;
      one = 64'd1 << FRAC;
      // Arithmetic shift floors, so adding half first rounds half up
      dx = px + ((off * sn + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
      dy = py - ((off * cs + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
      dz = pz - zm;
      cx = ((dy * tn + (64'sd1 <<< (FRAC - 1))) >>> FRAC)
         - ((dz * sn + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
      cy = ((dz * cs + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS)
         - ((dx * tn + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      cz = ((dx * sn + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS)
         - ((dy * cs + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
      mx = (cx < 0) ? -cx : cx;
      my = (cy < 0) ? -cy : cy;
      mz = (cz < 0) ? -cz : cz;
      sum = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
          + {64'd0, mz} * {64'd0, mz};
      // Floored square root, one bit at a time
      root = 0;
      for (int b = 50; b >= 0; b--) begin
        t = root | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= sum) root = t;
      end
      if (len == 0) len = 1;
      if (root >= (len << (32 - FRAC))) dst = 64'hFFFF_FFFF;
      else dst = (root << FRAC) / len;
      den = ((bin_size == 0) ? 64'd1 : 64'(bin_size)) * 2;
      ratio = (dst << FRAC) / den;
      if (ratio <= one) begin
        w = ((one - ratio) * fac) >> FRAC;
      end else begin
        neg = ratio - one;
        if (fac == 0) w = 0;
        else if (neg > (64'd1 << (31 + FRAC)) / fac) w = -64'sd2147483648;
        else w = -longint'((neg * fac + one - 1) >> FRAC);
      end
      res.distance = dst[31:0];
      res.weight = w[31:0];
      return res;
    endfunction

    function void note_item(in_item_t it);
      pending_q.push_back(predict(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result distance=%h weight=%h",
                 $time, got.distance, got.weight);
        errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (got.distance !== exp_res.distance) begin
        $display("%0t: distance mismatch expected=%h actual=%h",
                 $time, exp_res.distance, got.distance);
        errors++;
      end
      if (got.weight !== exp_res.weight) begin
        $display("%0t: weight mismatch expected=%h actual=%h",
                 $time, exp_res.weight, got.weight);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  pldw_chan_if #(.T(in_item_t))  in_ch ();
  pldw_chan_if #(.T(out_item_t)) out_ch ();

  dist_weight_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_cnt = 0;

  point_line_distance_weight_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL point_line_distance_weight_top");
      $finish;
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Check each result and toggle ready at random
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (!rst_n || hold_cycles > 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic apb_write(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_BIN_SIZE) sb.bin_size = value;
  endtask

  // Idle for a random number of cycles, then offer one item and hold it until taken
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] coord(bit wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  function automatic logic [15:0] trig();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    it.point_x = coord(wide);
    it.point_y = coord(wide);
    it.point_z = coord(wide);
    it.lor_offset = coord(wide);
    it.lor_mid_z = coord(wide);
    it.lor_sine = trig();
    it.lor_cosine = trig();
    it.lor_slope = wide ? 24'($urandom) : 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    it.dir_length = ($urandom_range(0, 1)) ? 24'($urandom_range(65536, 16777215))
                                           : 24'($urandom_range(65536, 140000));
    it.weight_factor = 20'($urandom);
    return it;
  endfunction

  function automatic in_item_t fill_item(logic [31:0] p, logic [15:0] s, logic [15:0] c,
                                         logic [23:0] tn, logic [23:0] len,
                                         logic [19:0] fac);
    in_item_t it;
    it.point_x = p; it.point_y = p; it.point_z = p;
    it.lor_offset = p; it.lor_mid_z = p;
    it.lor_sine = s; it.lor_cosine = c; it.lor_slope = tn;
    it.dir_length = len; it.weight_factor = fac;
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  initial begin
    in_item_t it;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes, point on the line, saturation both ways
    send_item(fill_item(32'h0, 16'sd0, 16'sd16384, 24'h0, 24'd65536, 20'hFFFFF));
    send_item(fill_item(32'h7FFF_FFFF, 16'sd16384, 16'sd0, 24'h7F_FFFF, 24'd65536, 20'hFFFFF));
    send_item(fill_item(32'h8000_0000, -16'sd16384, -16'sd16384, 24'h80_0000,
                        24'hFF_FFFF, 20'hFFFFF));
    send_item(fill_item(32'h8000_0000, 16'sd16384, -16'sd16384, 24'h80_0000,
                        24'd65536, 20'h0));
    send_item(fill_item(32'h7FFF_FFFF, -16'sd16384, 16'sd16384, 24'h7F_FFFF,
                        24'hFF_FFFF, 20'h0));
    send_item(fill_item(32'h0001_0000, 16'sd11585, 16'sd11585, 24'h01_0000,
                        24'd92682, 20'h10000));
    it = fill_item(32'h0, 16'sd0, 16'sd16384, 24'h0, 24'd65536, 20'h10000);
    it.point_x = 32'h0000_8000;
    send_item(it);
    it.point_x = 32'h0002_0000;
    send_item(it);
    it.point_y = 32'h0;
    it.point_z = 32'h0003_0000;
    it.lor_slope = 24'hFF_0000;
    send_item(it);
    for (int i = 0; i < 6; i++) send_item(rand_item());
    drain();

    // Phase one: sender idles sometimes, receiver often
    send_idle_pct = 14;
    recv_idle_pct = 45;
    apb_write(REG_BIN_SIZE, 32'd1);
    random_phase(RANDOM_ITEMS / 4);
    drain();

    // Phase two: the other way round, widest bin
    send_idle_pct = 45;
    recv_idle_pct = 14;
    apb_write(REG_BIN_SIZE, 32'hFFFF_FFFF);
    random_phase(RANDOM_ITEMS / 4);
    drain();

    // Phase three: no idling; hold the receiver off so the pipe backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(REG_BIN_SIZE, 32'h0002_0000);
    hold_cycles = 400;
    random_phase(RANDOM_ITEMS / 4);
    drain();

    // Phase four: random bin, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(REG_BIN_SIZE, $urandom_range(1, 32'h0040_0000));
    random_phase(RANDOM_ITEMS / 4);
    drain();

    if (sb.errors == 0) begin
      $display("PASS point_line_distance_weight_top");
    end else begin
      $display("FAIL point_line_distance_weight_top");
    end
    $finish;
  end
endmodule
